@@ design/thermal_window_detector_defines.svh @@
// Assertion macros for the thermal window detector.
// Depends on nothing; included by the top level only.
`ifndef THERMAL_WINDOW_DETECTOR_DEFINES_SVH
`define THERMAL_WINDOW_DETECTOR_DEFINES_SVH
`ifndef SYNTH
// condition that must hold at every edge out of reset
`define TWD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("thermal window detector check failed");
// antecedent implies consequent in the next cycle
`define TWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("thermal window detector check failed");
`else
`define TWD_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define TWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/twd_pkg.sv @@
// Shared types and constants of the thermal window detector.
// No dependencies; used by the interfaces, the divider and the top level.
package twd_pkg;

	localparam int TimeW = 23;
	localparam int LatW = 31;
	localparam int LonW = 32;
	localparam int AltW = 15;
	localparam int CrsW = 9;
	localparam int CfgIdxW = 8;
	localparam int CfgDatW = 16;
	localparam int DivNumW = 22;
	localparam int DivDenW = 8;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_WINDOW = 8'd0,
		REG_MIN_GAIN = 8'd1,
		REG_MIN_TURN = 8'd2,
		REG_HYST = 8'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_C_RD, ST_C_EV, ST_DIV_GO, ST_DIV_WAIT,
		ST_WRITE, ST_W_SET, ST_W_RD, ST_W_EV, ST_FINAL, ST_OUT
	} state_t;

	// one stored sample
	typedef struct packed {
		logic [TimeW-1:0] tim;
		logic signed [AltW-1:0] alt;
		logic [CrsW-1:0] crs;
	} sample_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ design/twd_fix_if.sv @@
// Channel interfaces: fix input, result output and register write.
// Depends on twd_pkg for field widths.
interface twd_fix_if;
	import twd_pkg::*;
	logic valid;
	logic ready;
	logic fix_ok;
	logic [TimeW-1:0] time_s;
	logic signed [LatW-1:0] lat_e7;
	logic signed [LonW-1:0] lon_e7;
	logic signed [AltW-1:0] alt_m;
	logic [CrsW-1:0] course_deg;
	modport source (output valid, fix_ok, time_s, lat_e7, lon_e7, alt_m, course_deg,
		input ready);
	modport sink (input valid, fix_ok, time_s, lat_e7, lon_e7, alt_m, course_deg,
		output ready);
endinterface

interface twd_res_if;
	logic valid;
	logic ready;
	logic accepted;
	logic signed [15:0] climb_cms;
	logic signed [14:0] window_gain_m;
	logic [15:0] turn_arc_deg;
	logic thermal_flag;
	logic episode_start;
	logic episode_end;
	modport source (output valid, accepted, climb_cms, window_gain_m, turn_arc_deg,
		thermal_flag, episode_start, episode_end, input ready);
	modport sink (input valid, accepted, climb_cms, window_gain_m, turn_arc_deg,
		thermal_flag, episode_start, episode_end, output ready);
endinterface

interface twd_cfg_if;
	import twd_pkg::*;
	logic valid;
	logic ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDatW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/twd_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on twd_pkg.
module twd_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [twd_pkg::DivNumW-1:0] num,
	input logic [twd_pkg::DivDenW-1:0] den,
	output logic [twd_pkg::DivNumW-1:0] quo,
	output twd_pkg::div_stat_t stat
);
	import twd_pkg::*;

	localparam int CntW = $clog2(DivNumW + 1);

	logic [DivDenW-1:0] rem_q;
	logic [DivDenW-1:0] den_q;
	logic [DivNumW-1:0] quo_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DivDenW:0] trial;
	logic fits;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, quo_q[DivNumW-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(DivNumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
			quo_q <= {quo_q[DivNumW-2:0], fits};
		end
	end

	assign quo = quo_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

@@ design/thermal_window_detector.sv @@
// Thermal window detector. Per fix it walks N stored samples for the climb rate and M,
// the stored count (up to RING_DEPTH), for the window; each sample read has a read state
// and an evaluate state, and the climb rate comes from a 22-bit divider. A skipped fix
// goes straight from the check state to output. One fix in flight; a finished word may
// wait at the output. arst_n clears control state, wp_q, episode state and registers to
// reset values; the sample ring itself is not cleared.
module thermal_window_detector #(
	parameter int RING_DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	twd_fix_if.sink fix,
	twd_res_if.source res,
	twd_cfg_if.sink cfg
);
	import twd_pkg::*;

	localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam logic [PW-1:0] LastIdx = PW'(RING_DEPTH - 1);

	state_t state_q, state_d;

	// registers
	logic [7:0] win_q;
	logic [10:0] min_gain_q;
	logic [11:0] min_turn_q;
	logic [8:0] hyst_q;

	// latched fix
	logic f_ok_q;
	logic [TimeW-1:0] f_time_q;
	logic signed [LatW-1:0] f_lat_q;
	logic signed [LonW-1:0] f_lon_q;
	logic signed [AltW-1:0] f_alt_q;
	logic [CrsW-1:0] f_crs_q;

	logic [TimeW-1:0] last_time_q, bt_q;
	logic signed [LatW-1:0] last_lat_q;
	logic signed [LonW-1:0] last_lon_q;
	logic ep_act_q, bv_q;

	logic [PW-1:0] wp_q, idx_q;
	logic [CW-1:0] cnt_q, off_q;
	sample_t mem_q [RING_DEPTH];
	sample_t rd_q;

	// climb search
	logic cf_q;
	logic signed [15:0] cdiff_q, climb_q;
	logic [7:0] cdt_q;

	// window walk
	logic [1:0] nwin_q;
	logic signed [AltW-1:0] first_alt_q, last_alt_q;
	logic [CrsW-1:0] prev_crs_q;
	logic dir_set_q, dir_pos_q;
	logic [15:0] arc_q, rev_q, best_q;

	// result word being built
	logic r_valid_q, r_acc_q, r_th_q, r_st_q, r_en_q;
	logic signed [15:0] r_climb_q;
	logic signed [14:0] r_gain_q;
	logic [15:0] r_arc_q;

	// result word on offer
	logic o_acc_q, o_th_q, o_st_q, o_en_q;
	logic signed [15:0] o_climb_q;
	logic signed [14:0] o_gain_q;
	logic [15:0] o_arc_q;

	logic fix_take, repeat_fix, last_off, c_later, c_inwin, w_incl;
	logic [TimeW-1:0] dt;
	logic div_start;
	logic [DivNumW-1:0] div_q;
	div_stat_t div_st;
	logic signed [22:0] prod;
	logic [DivNumW-1:0] prod_mag;

	assign fix.ready = (state_q == ST_IDLE);
	assign fix_take = fix.valid && fix.ready;
	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 8'd30;
			min_gain_q <= 11'd10;
			min_turn_q <= 12'd360;
			hyst_q <= 9'd45;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WINDOW: win_q <= cfg.data[7:0];
				REG_MIN_GAIN: min_gain_q <= cfg.data[10:0];
				REG_MIN_TURN: min_turn_q <= cfg.data[11:0];
				REG_HYST: hyst_q <= cfg.data[8:0];
				default: ;
			endcase
		end
	end

	// walk helpers
	assign repeat_fix = (f_time_q == last_time_q) ||
		(f_lat_q == last_lat_q && f_lon_q == last_lon_q);
	assign last_off = (off_q == cnt_q);
	assign dt = f_time_q - rd_q.tim;
	assign c_later = f_time_q > rd_q.tim;
	assign c_inwin = dt <= {{(TimeW-8){1'b0}}, win_q};
	assign w_incl = (rd_q.tim <= f_time_q) && c_inwin && !(bv_q && rd_q.tim <= bt_q);

	// one step of the turn arc tracker
	logic signed [9:0] dd;
	logic [7:0] mag;
	logic pos;
	logic [15:0] arc_n, rev_n, best_n, rev_sum, best_t;
	logic dir_pos_n;
	always_comb begin
		dd = $signed({1'b0, rd_q.crs}) - $signed({1'b0, prev_crs_q});
		if (dd > 10'sd180) dd = dd - 10'sd360;
		else if (dd < -10'sd180) dd = dd + 10'sd360;
		pos = dd > 10'sd0;
		mag = pos ? dd[7:0] : 8'(-dd);
		rev_sum = rev_q + {8'd0, mag};
		arc_n = arc_q;
		rev_n = rev_q;
		best_t = best_q;
		dir_pos_n = dir_pos_q;
		if (dd != 10'sd0) begin
			if (!dir_set_q) begin
				dir_pos_n = pos;
				arc_n = {8'd0, mag};
			end else if (pos == dir_pos_q) begin
				rev_n = '0;
				arc_n = arc_q + {8'd0, mag};
			end else if (rev_sum >= {7'd0, hyst_q}) begin
				if (arc_q > best_t) best_t = arc_q;
				dir_pos_n = pos;
				arc_n = rev_sum;
				rev_n = '0;
			end else begin
				rev_n = rev_sum;
			end
		end
		best_n = (arc_n > best_t) ? arc_n : best_t;
	end

	// final evaluation of the window
	logic signed [15:0] gain;
	logic [15:0] arc_fin;
	logic thermal;
	logic signed [14:0] gain_sat;
	always_comb begin
		gain = (nwin_q == 2'd2) ? (16'(last_alt_q) - 16'(first_alt_q)) : 16'sd0;
		arc_fin = (nwin_q != 2'd2) ? 16'd0 : ((arc_q > best_q) ? arc_q : best_q);
		thermal = (nwin_q == 2'd2) && (gain >= $signed({5'd0, min_gain_q})) &&
			(arc_fin >= {4'd0, min_turn_q});
		if (gain > 16'sd16383) gain_sat = 15'sd16383;
		else if (gain < -16'sd16384) gain_sat = -15'sd16384;
		else gain_sat = gain[14:0];
	end

	// climb dividend
	assign prod = 23'(cdiff_q) * 23'sd100;
	assign prod_mag = prod[22] ? DivNumW'(-prod) : prod[DivNumW-1:0];
	assign div_start = (state_q == ST_DIV_GO) && cf_q;

	twd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(prod_mag), .den(cdt_q),
		.quo(div_q), .stat(div_st)
	);

	// signed, saturated quotient
	logic signed [15:0] climb_v;
	always_comb begin
		if (prod[22]) climb_v = (div_q > DivNumW'(32768)) ? -16'sd32768 : 16'(-div_q);
		else climb_v = (div_q > DivNumW'(32767)) ? 16'sd32767 : div_q[15:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (fix_take) state_d = ST_CHECK;
			ST_CHECK: begin
				if (!f_ok_q || repeat_fix) state_d = ST_OUT;
				else if (cnt_q == '0) state_d = ST_WRITE;
				else state_d = ST_C_RD;
			end
			ST_C_RD: state_d = ST_C_EV;
			ST_C_EV: begin
				if ((c_later && !c_inwin) || last_off) state_d = ST_DIV_GO;
				else state_d = ST_C_RD;
			end
			ST_DIV_GO: state_d = cf_q ? ST_DIV_WAIT : ST_WRITE;
			ST_DIV_WAIT: if (div_st.done) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_W_SET;
			ST_W_SET: state_d = (cnt_q < CW'(2)) ? ST_OUT : ST_W_RD;
			ST_W_RD: state_d = ST_W_EV;
			ST_W_EV: state_d = last_off ? ST_FINAL : ST_W_RD;
			ST_FINAL: state_d = ST_OUT;
			ST_OUT: if (!r_valid_q || res.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			cnt_q <= '0;
			last_time_q <= '0;
			last_lat_q <= '0;
			last_lon_q <= '0;
			ep_act_q <= 1'b0;
			bv_q <= 1'b0;
			bt_q <= '0;
			r_valid_q <= 1'b0;
		end else begin
			if (res.ready) r_valid_q <= 1'b0;
			if (state_q == ST_OUT && (!r_valid_q || res.ready)) r_valid_q <= 1'b1;
			if (state_q == ST_CHECK && f_ok_q && !repeat_fix) begin
				last_time_q <= f_time_q;
				last_lat_q <= f_lat_q;
				last_lon_q <= f_lon_q;
			end
			if (state_q == ST_WRITE) begin
				wp_q <= (wp_q == LastIdx) ? '0 : wp_q + 1'b1;
				if (cnt_q < CW'(RING_DEPTH)) cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_FINAL) begin
				if (thermal) ep_act_q <= 1'b1;
				else if (ep_act_q) begin
					ep_act_q <= 1'b0;
					bt_q <= f_time_q;
					bv_q <= 1'b1;
				end
			end
		end
	end

	// sample ring, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) mem_q[wp_q] <= '{tim: f_time_q, alt: f_alt_q, crs: f_crs_q};
		if (state_q == ST_C_RD || state_q == ST_W_RD) rd_q <= mem_q[idx_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (fix_take) begin
					f_ok_q <= fix.fix_ok;
					f_time_q <= fix.time_s;
					f_lat_q <= fix.lat_e7;
					f_lon_q <= fix.lon_e7;
					f_alt_q <= fix.alt_m;
					f_crs_q <= fix.course_deg;
				end
			end
			ST_CHECK: begin
				cf_q <= 1'b0;
				climb_q <= '0;
				idx_q <= (wp_q == '0) ? LastIdx : wp_q - 1'b1;
				off_q <= CW'(1);
				r_acc_q <= 1'b0;
				r_climb_q <= '0;
				r_gain_q <= '0;
				r_arc_q <= '0;
				r_th_q <= 1'b0;
				r_st_q <= 1'b0;
				r_en_q <= 1'b0;
			end
			ST_C_EV: begin
				if (c_later && c_inwin) begin
					cf_q <= 1'b1;
					cdiff_q <= 16'(f_alt_q) - 16'(rd_q.alt);
					cdt_q <= dt[7:0];
				end
				off_q <= off_q + 1'b1;
				idx_q <= (idx_q == '0) ? LastIdx : idx_q - 1'b1;
			end
			ST_DIV_WAIT: if (div_st.done) climb_q <= climb_v;
			ST_W_SET: begin
				r_acc_q <= 1'b1;
				r_climb_q <= climb_q;
				idx_q <= (cnt_q == CW'(RING_DEPTH)) ? wp_q : '0;
				off_q <= CW'(1);
				nwin_q <= '0;
				dir_set_q <= 1'b0;
				dir_pos_q <= 1'b0;
				arc_q <= '0;
				rev_q <= '0;
				best_q <= '0;
			end
			ST_W_EV: begin
				off_q <= off_q + 1'b1;
				idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
				if (w_incl) begin
					prev_crs_q <= rd_q.crs;
					if (nwin_q == 2'd0) begin
						first_alt_q <= rd_q.alt;
						nwin_q <= 2'd1;
					end else begin
						last_alt_q <= rd_q.alt;
						nwin_q <= 2'd2;
						arc_q <= arc_n;
						rev_q <= rev_n;
						best_q <= best_n;
						dir_pos_q <= dir_pos_n;
						if (dd != 10'sd0) dir_set_q <= 1'b1;
					end
				end
			end
			ST_FINAL: begin
				r_gain_q <= gain_sat;
				r_arc_q <= arc_fin;
				r_th_q <= thermal;
				r_st_q <= thermal && !ep_act_q;
				r_en_q <= !thermal && ep_act_q;
			end
			default: ;
		endcase
	end

	// output word, loaded as the finished word leaves the sequencer
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!r_valid_q || res.ready)) begin
			o_acc_q <= r_acc_q;
			o_climb_q <= r_climb_q;
			o_gain_q <= r_gain_q;
			o_arc_q <= r_arc_q;
			o_th_q <= r_th_q;
			o_st_q <= r_st_q;
			o_en_q <= r_en_q;
		end
	end

	assign res.valid = r_valid_q;
	assign res.accepted = o_acc_q;
	assign res.climb_cms = o_climb_q;
	assign res.window_gain_m = o_gain_q;
	assign res.turn_arc_deg = o_arc_q;
	assign res.thermal_flag = o_th_q;
	assign res.episode_start = o_st_q;
	assign res.episode_end = o_en_q;

`include "thermal_window_detector_defines.svh"

	`TWD_ASSERT_ALWAYS(a_count_bound, clk, arst_n, cnt_q <= CW'(RING_DEPTH))
	`TWD_ASSERT_ALWAYS(a_start_end_excl, clk, arst_n, !(r_valid_q && o_st_q && o_en_q))
	`TWD_ASSERT_ALWAYS(a_skip_zero, clk, arst_n, !(r_valid_q && !o_acc_q && o_climb_q != 16'sd0))
	`TWD_ASSERT_NEXT(a_div_busy, clk, arst_n, div_start, div_st.busy)

endmodule

@@ bench/twd_checker.sv @@
// Scoreboard for the thermal window detector: predicts each result word and compares it.
// Depends on twd_pkg and the channel interfaces in twd_fix_if.sv.
module twd_checker (
	input logic clk,
	input logic arst_n,
	twd_fix_if fix,
	twd_res_if res,
	twd_cfg_if cfg,
	output int errors,
	output int pending,
	output int n_words,
	output int n_stored_fixes,
	output int n_thermal,
	output int n_episodes
);
	timeunit 1ns;
	timeprecision 1ps;
	import twd_pkg::*;

	localparam int DEPTH = 64;

	typedef struct packed {
		logic accepted;
		logic signed [15:0] climb;
		logic signed [14:0] gain;
		logic [15:0] arc;
		logic thermal;
		logic ep_start;
		logic ep_end;
	} word_t;

	word_t expected_words[$];

	// model copy of the sample ring and tracking state
	int unsigned smp_time[DEPTH];
	int smp_alt[DEPTH];
	int smp_crs[DEPTH];
	int unsigned wr_ptr, n_stored, last_sec, bnd_time;
	int last_lat, last_lon;
	bit ep_active, bnd_valid;

	// register copies
	int unsigned win_s, gain_min, turn_min, hyst;

	initial begin
		wr_ptr = 0; n_stored = 0; last_sec = 0; bnd_time = 0;
		last_lat = 0; last_lon = 0; ep_active = 0; bnd_valid = 0;
		win_s = 30; gain_min = 10; turn_min = 360; hyst = 45;
		errors = 0; pending = 0; n_words = 0;
		n_stored_fixes = 0; n_thermal = 0; n_episodes = 0;
	end

	function automatic int unsigned slot(int unsigned back);
		return (wr_ptr + DEPTH - back) % DEPTH;
	endfunction

	// longest one-way heading sweep over the window, with reversal hysteresis
	function automatic int unsigned sweep_arc(int unsigned idx[DEPTH], int unsigned n);
		int dir, prev, cur, d, ddir;
		int unsigned arc, rev, best, mag;
		dir = 0; arc = 0; rev = 0; best = 0;
		prev = smp_crs[idx[0]];
		for (int unsigned i = 1; i < n; i++) begin
			cur = smp_crs[idx[i]];
			d = cur - prev;
			while (d > 180) d -= 360;
			while (d < -180) d += 360;
			prev = cur;
			if (d == 0) continue;
			ddir = d > 0 ? 1 : -1;
			mag = d > 0 ? d : -d;
			if (dir == 0) begin
				dir = ddir;
				arc = mag;
			end else if (ddir == dir) begin
				rev = 0;
				arc += mag;
			end else begin
				rev += mag;
				if (rev >= hyst) begin
					if (arc > best) best = arc;
					dir = ddir;
					arc = rev;
					rev = 0;
				end
			end
			if (arc > best) best = arc;
		end
		return arc > best ? arc : best;
	endfunction

	// expected word for one fix; updates the model state
	function automatic word_t predict_fix(logic ok, logic [TimeW-1:0] t,
			logic signed [LatW-1:0] la, logic signed [LonW-1:0] lo,
			logic signed [AltW-1:0] al, logic [CrsW-1:0] cr);
		word_t w;
		int unsigned tt, dt, nt, n, j, st, arc;
		int la_i, lo_i, alt_i, climb, gain, v;
		int unsigned win[DEPTH];
		bit therm;
		w = '0;
		if (!ok) return w;
		tt = t; la_i = la; lo_i = lo; alt_i = al;
		if (tt == last_sec || (la_i == last_lat && lo_i == last_lon)) return w;
		last_sec = tt; last_lat = la_i; last_lon = lo_i;

		// climb against the oldest earlier sample still inside the window
		climb = 0;
		for (int unsigned off = 1; off <= n_stored; off++) begin
			j = slot(off);
			if (tt <= smp_time[j]) continue;
			dt = tt - smp_time[j];
			if (dt > win_s) break;
			v = ((alt_i - smp_alt[j]) * 100) / int'(dt);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			climb = v;
		end

		smp_time[wr_ptr] = tt;
		smp_alt[wr_ptr] = alt_i;
		smp_crs[wr_ptr] = cr;
		wr_ptr = (wr_ptr + 1) % DEPTH;
		if (n_stored < DEPTH) n_stored++;

		w.accepted = 1'b1;
		w.climb = climb[15:0];
		if (n_stored < 2) return w;

		// collect the detection window, oldest first
		nt = smp_time[slot(1)];
		n = 0;
		for (int unsigned off = n_stored; off >= 1; off--) begin
			j = slot(off);
			st = smp_time[j];
			if (nt < st || nt - st > win_s) continue;
			if (bnd_valid && st <= bnd_time) continue;
			win[n] = j;
			n++;
		end

		gain = 0; arc = 0; therm = 0;
		if (n >= 2) begin
			gain = smp_alt[win[n-1]] - smp_alt[win[0]];
			arc = sweep_arc(win, n);
			therm = gain >= int'(gain_min) && arc >= turn_min;
		end

		// episode tracking
		if (therm) begin
			if (!ep_active) begin
				ep_active = 1;
				w.ep_start = 1'b1;
			end
		end else if (ep_active) begin
			ep_active = 0;
			bnd_time = nt;
			bnd_valid = 1;
			w.ep_end = 1'b1;
		end

		if (gain > 16383) gain = 16383;
		if (gain < -16384) gain = -16384;
		if (arc > 65535) arc = 65535;
		w.gain = gain[14:0];
		w.arc = arc[15:0];
		w.thermal = therm;
		return w;
	endfunction

	always @(posedge clk) begin
		word_t got, exp_w;
		if (arst_n) begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_WINDOW: win_s = cfg.data[7:0];
					REG_MIN_GAIN: gain_min = cfg.data[10:0];
					REG_MIN_TURN: turn_min = cfg.data[11:0];
					REG_HYST: hyst = cfg.data[8:0];
					default: ;
				endcase
			end
			// incoming fix
			if (fix.valid && fix.ready) begin
				expected_words.push_back(predict_fix(fix.fix_ok, fix.time_s, fix.lat_e7,
					fix.lon_e7, fix.alt_m, fix.course_deg));
			end
			// outgoing word
			if (res.valid && res.ready) begin
				got = '{res.accepted, res.climb_cms, res.window_gain_m, res.turn_arc_deg,
					res.thermal_flag, res.episode_start, res.episode_end};
				n_words++;
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result word with none expected: %p", $realtime, got);
				end else begin
					exp_w = expected_words.pop_front();
					if (got !== exp_w) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch\n  expected %p\n  actual   %p",
								$realtime, exp_w, got);
					end
					if (exp_w.accepted) n_stored_fixes++;
					if (exp_w.thermal) n_thermal++;
					if (exp_w.ep_start) n_episodes++;
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
// Top of the thermal window detector bench: clock, reset, stimulus and verdict.
// Depends on twd_pkg, the channel interfaces, twd_checker and the detector itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import twd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	twd_fix_if fix_ch();
	twd_res_if res_ch();
	twd_cfg_if cfg_ch();

	int errors, pending, n_words, n_stored_fixes, n_thermal, n_episodes;
	bit quiet = 0;      // no idling on either side
	bit hold_req = 0;   // ask the receiver for a long hold-off
	bit hold = 0;

	// flight state for well-formed sequences
	int unsigned cur_t;
	int cur_lat, cur_lon, cur_alt, cur_crs, climb_mps, turn_dps;
	int n_counted;

	thermal_window_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.fix(fix_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	twd_checker chk (
		.clk(clk), .arst_n(arst_n), .fix(fix_ch), .res(res_ch), .cfg(cfg_ch),
		.errors(errors), .pending(pending), .n_words(n_words),
		.n_stored_fixes(n_stored_fixes), .n_thermal(n_thermal), .n_episodes(n_episodes)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= !hold && (quiet || $urandom_range(99) >= 25);
		end
	end

	initial begin
		@(posedge hold_req);
		@(posedge clk);
		hold <= 1'b1;
		repeat (800) @(posedge clk);
		hold <= 1'b0;
	end

	// offer one fix word and wait for it to be taken
	task automatic send_fix(int ok, int unsigned t, int la, int lo, int al, int cr);
		if (!quiet && $urandom_range(99) < 25) begin
			fix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		fix_ch.valid <= 1'b1;
		fix_ch.fix_ok <= ok[0];
		fix_ch.time_s <= TimeW'(t);
		fix_ch.lat_e7 <= LatW'(la);
		fix_ch.lon_e7 <= LonW'(lo);
		fix_ch.alt_m <= AltW'(al);
		fix_ch.course_deg <= CrsW'(cr);
		do @(posedge clk); while (!fix_ch.ready);
	endtask

	// wait until every expected word is back and the block has settled
	task automatic wait_idle();
		fix_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CfgDatW'(val);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_regs(int w, int g, int tr, int h);
		wait_idle();
		write_reg(REG_WINDOW, w);
		write_reg(REG_MIN_GAIN, g);
		write_reg(REG_MIN_TURN, tr);
		write_reg(REG_HYST, h);
	endtask

	// next fix along the current flight pattern
	task automatic flight_fix();
		cur_t = (cur_t + $urandom_range(1, 3)) & 23'h7FFFFF;
		if (cur_t == 0) cur_t = 1;
		cur_lat += $urandom_range(1, 500);
		cur_lon -= $urandom_range(0, 500);
		cur_alt += climb_mps + $signed($urandom_range(0, 4)) - 2;
		if (cur_alt > 12000 || cur_alt < -2000) cur_alt = 1000;
		cur_crs = (cur_crs + turn_dps + 360) % 360;
		send_fix(1, cur_t, cur_lat, cur_lon, cur_alt, cur_crs);
	endtask

	// one random item: mostly flight, some noise and deliberate repeats
	task automatic random_item();
		int sel;
		sel = $urandom_range(99);
		n_counted++;
		if (sel < 70) begin
			flight_fix();
		end else if (sel < 77) begin
			send_fix(0, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else if (sel < 82) begin
			// repeat of the last second
			send_fix(1, cur_t, cur_lat + 7, cur_lon, cur_alt, cur_crs);
		end else if (sel < 87) begin
			// repeat of the last position
			send_fix(1, cur_t + 1, cur_lat, cur_lon, cur_alt, cur_crs);
		end else if (sel < 94) begin
			send_fix(1, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else begin
			// jump in time, backwards or far ahead
			if ($urandom_range(1)) cur_t = cur_t - $urandom_range(1, 100);
			else cur_t = cur_t + $urandom_range(30, 400);
			flight_fix();
		end
		if ($urandom_range(39) == 0) begin
			climb_mps = $signed($urandom_range(0, 12)) - 4;
			turn_dps = $signed($urandom_range(0, 90)) - 45;
		end else if ($urandom_range(49) == 0) begin
			turn_dps = -turn_dps;
		end
	endtask

	initial begin
		int cfg_sets[6][4];
		fix_ch.valid <= 1'b0;
		fix_ch.fix_ok <= 1'b0;
		fix_ch.time_s <= '0;
		fix_ch.lat_e7 <= '0;
		fix_ch.lon_e7 <= '0;
		fix_ch.alt_m <= '0;
		fix_ch.course_deg <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_WINDOW;
		cfg_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: invalid, zero second, zero position, field extremes
		send_fix(0, 10, 5, 5, 0, 0);
		send_fix(1, 0, 5, 5, 0, 0);
		send_fix(1, 5, 0, 0, 0, 0);
		send_fix(1, 6, -900000000, -1800000000, -2000, 0);
		send_fix(1, 7, 900000000, 1800000000, 12000, 359);
		send_fix(1, 7, 1, 1, 100, 10);
		send_fix(1, 8, 900000000, 1800000000, 100, 10);
		send_fix(1, 9, 2, 2, -16384, 511);
		send_fix(1, 10, 3, 3, 16383, 0);
		send_fix(1, 4294967, -1073741824, 32'sh80000000, 0, 180);
		send_fix(1, 8388607, 1073741823, 2147483647, 5, 200);
		// climbing turn to open an episode, then a sink to close it
		cur_t = 100; cur_lat = 1000; cur_lon = 1000; cur_alt = 500; cur_crs = 0;
		climb_mps = 3; turn_dps = 40;
		repeat (11) flight_fix();
		climb_mps = -6; turn_dps = 0;
		repeat (3) flight_fix();

		// random phases across register settings
		cfg_sets = '{'{1, 0, 0, 1}, '{255, 2000, 4000, 360}, '{30, 10, 360, 45},
			'{60, 5, 200, 20}, '{12, 0, 90, 360}, '{90, 30, 720, 90}};
		n_counted = 0;
		for (int ph = 0; ph < 6; ph++) begin
			set_regs(cfg_sets[ph][0], cfg_sets[ph][1], cfg_sets[ph][2], cfg_sets[ph][3]);
			climb_mps = 2; turn_dps = 30;
			while (n_counted < (ph + 1) * 300) begin
				if (ph == 2 && n_counted == 650) quiet <= 1'b1;
				if (ph == 2 && n_counted == 800) quiet <= 1'b0;
				if (ph == 3 && n_counted == 950) hold_req <= 1'b1;
				random_item();
			end
		end

		wait_idle();
		repeat (300) @(posedge clk);
		$display("Checked %0d result words: %0d fixes stored, %0d thermal, %0d episodes.",
			n_words, n_stored_fixes, n_thermal, n_episodes);
		$display("Six register settings used, extremes included; %0d mismatches.", errors);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
